// File: src/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared widths, codes and cell control types for the ordered list core.
// ----------------------------------------------------------------------------
package olid_pkg;

  localparam int DEPTH_DEF = 128;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int POS_W     = 8;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  // What every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_KEEP   = 2'd2,
    OP_DROP   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t            op;
    logic [DATA_W-1:0]   data;
  } cell_ctl_t;

endpackage

// File: src/ordered_list_insert_delete_core.sv
// Insert, out-of-range requests, KIND_NONE requests and deletes on an empty list: result
// is registered in the cycle after the request is taken; the chain of cells shifts with it.
// Delete and in-range read: the list circulates past cell 0 one entry per cycle in
// S_PASS, then S_DONE posts the result once the output register is free.
// Sequential: the next request is taken in S_IDLE once the result register is free.
// Reset clears the length and handshake state; cells are never read before written.
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_core
// Ordered list of signed words held in a row of cells with insert at a
// position, delete of all equal entries, and read at a position.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_core #(
  parameter int DEPTH = olid_pkg::DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [olid_pkg::KIND_W-1:0]          kind,
  input  logic [olid_pkg::POS_W-1:0]           position,
  input  logic signed [olid_pkg::DATA_W-1:0]   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [olid_pkg::STATUS_W-1:0]        status,
  output logic [olid_pkg::CNT_OUT_W-1:0]       removed_count,
  output logic [olid_pkg::CNT_OUT_W-1:0]       length,
  output logic signed [olid_pkg::DATA_W-1:0]   read_value
);
  import olid_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PASS = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         step, step_next;
  logic [CW-1:0]         kept, kept_next;
  logic [CW-1:0]         removed, removed_next;
  logic [CW-1:0]         read_idx, read_idx_next;
  logic [IW-1:0]         tail, tail_next;
  logic                  is_read, is_read_next;
  logic [DATA_W-1:0]     match_val, match_val_next;
  logic [DATA_W-1:0]     rd_data, rd_data_next;

  logic                  out_valid_next;
  logic [STATUS_W-1:0]   status_next;
  logic [CNT_OUT_W-1:0]  removed_count_next;
  logic [CNT_OUT_W-1:0]  length_next;
  logic [DATA_W-1:0]     read_value_next;

  cell_ctl_t             ctl;
  logic [IW-1:0]         target;
  logic [DATA_W-1:0]     cell_q [DEPTH];

  logic                  slot_free;
  logic                  accept;
  logic                  keep;
  logic [DATA_W-1:0]     head;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         cnt_w;
  logic                  ins_ok;
  logic                  rd_ok;
  logic                  full;
  logic [CW-1:0]         kept_inc;

  // --------------------------------------------------------------------------
  // Chain of cells
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = cell_q[i];
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    olid_cell #(
      .IW    (IW),
      .INDEX (i)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .target (target),
      .left   (left_w),
      .right  (right_w),
      .q      (cell_q[i])
    );
  end

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = !((state == S_IDLE) && slot_free);
  assign accept    = in_valid && !in_stall;
  assign head      = cell_q[0];
  assign keep      = is_read || (head != match_val);
  assign kept_inc  = kept + CW'(1);

  assign pos_w  = PW'(position);
  assign cnt_w  = PW'(count);
  assign ins_ok = (pos_w != '0) && (pos_w <= cnt_w + PW'(1));
  assign rd_ok  = (pos_w != '0) && (pos_w <= cnt_w);
  assign full   = (count == CW'(DEPTH));

  always_comb begin
    state_next         = state;
    count_next         = count;
    step_next          = step;
    kept_next          = kept;
    removed_next       = removed;
    read_idx_next      = read_idx;
    tail_next          = tail;
    is_read_next       = is_read;
    match_val_next     = match_val;
    rd_data_next       = rd_data;
    out_valid_next     = out_valid && out_stall;
    status_next        = status;
    removed_count_next = removed_count;
    length_next        = length;
    read_value_next    = read_value;
    ctl.op             = OP_HOLD;
    ctl.data           = value;
    target             = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind_t'(kind))
            KIND_INSERT: begin
              out_valid_next     = 1'b1;
              removed_count_next = '0;
              read_value_next    = '0;
              length_next        = CNT_OUT_W'(count);
              if (!ins_ok) begin
                status_next = STATUS_RANGE;
              end else if (full) begin
                status_next = STATUS_FULL;
              end else begin
                status_next = STATUS_OK;
                ctl.op      = OP_INSERT;
                target      = IW'(position - POS_W'(1));
                count_next  = count + CW'(1);
                length_next = CNT_OUT_W'(count + CW'(1));
              end
            end
            KIND_DELETE: begin
              if (count == '0) begin
                out_valid_next     = 1'b1;
                status_next        = STATUS_OK;
                removed_count_next = '0;
                length_next        = '0;
                read_value_next    = '0;
              end else begin
                is_read_next   = 1'b0;
                match_val_next = value;
                step_next      = '0;
                kept_next      = '0;
                tail_next      = IW'(count - CW'(1));
                state_next     = S_PASS;
              end
            end
            KIND_READ: begin
              if (!rd_ok) begin
                out_valid_next     = 1'b1;
                status_next        = STATUS_RANGE;
                removed_count_next = '0;
                length_next        = CNT_OUT_W'(count);
                read_value_next    = '0;
              end else begin
                is_read_next  = 1'b1;
                read_idx_next = CW'(position - POS_W'(1));
                step_next     = '0;
                kept_next     = '0;
                tail_next     = IW'(count - CW'(1));
                state_next    = S_PASS;
              end
            end
            KIND_NONE: begin
              out_valid_next     = 1'b1;
              status_next        = STATUS_OK;
              removed_count_next = '0;
              length_next        = CNT_OUT_W'(count);
              read_value_next    = '0;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_PASS: begin
        // pop the head; push it back at the tail unless it is dropped
        ctl.data = head;
        if (keep) begin
          ctl.op    = OP_KEEP;
          target    = tail;
          kept_next = kept_inc;
        end else begin
          ctl.op    = OP_DROP;
          tail_next = tail - IW'(1);
        end
        if (is_read && (step == read_idx)) begin
          rd_data_next = head;
        end
        if (step == count - CW'(1)) begin
          state_next = S_DONE;
          if (!is_read) begin
            count_next   = keep ? kept_inc : kept;
            removed_next = count - (keep ? kept_inc : kept);
          end
        end else begin
          step_next = step + CW'(1);
        end
      end

      S_DONE: begin
        if (slot_free) begin
          out_valid_next     = 1'b1;
          status_next        = STATUS_OK;
          removed_count_next = is_read ? '0 : CNT_OUT_W'(removed);
          length_next        = CNT_OUT_W'(count);
          read_value_next    = is_read ? rd_data : '0;
          state_next         = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    step          <= step_next;
    kept          <= kept_next;
    removed       <= removed_next;
    read_idx      <= read_idx_next;
    tail          <= tail_next;
    is_read       <= is_read_next;
    match_val     <= match_val_next;
    rd_data       <= rd_data_next;
    status        <= status_next;
    removed_count <= removed_count_next;
    length        <= length_next;
    read_value    <= read_value_next;
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> (state == S_IDLE))
    else $error("request taken while a pass is running");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("list length above capacity");

  a_kept_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_PASS) |-> (kept <= step))
    else $error("more entries kept than popped");

  a_done_result: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && slot_free) |=> (out_valid && (state == S_IDLE)))
    else $error("finished pass gave no result");

endmodule

// File: src/olid_cell.sv
// ----------------------------------------------------------------------------
// olid_cell
// One slot of the list. Takes a new word, its left neighbour's word or its
// right neighbour's word as the broadcast control asks.
// ----------------------------------------------------------------------------
module olid_cell #(
  parameter int IW    = 7,
  parameter int INDEX = 0
) (
  input  logic                           clk,
  input  olid_pkg::cell_ctl_t            ctl,
  input  logic [IW-1:0]                  target,
  input  logic [olid_pkg::DATA_W-1:0]    left,
  input  logic [olid_pkg::DATA_W-1:0]    right,
  output logic [olid_pkg::DATA_W-1:0]    q
);
  import olid_pkg::*;

  localparam logic [IW-1:0] IDX = IW'(INDEX);

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INSERT: begin
        // open a gap at the target, slots above it move up one place
        if (IDX == target) begin
          q <= ctl.data;
        end else if (IDX > target) begin
          q <= left;
        end
      end
      OP_KEEP: begin
        // advance towards the head, the tail slot takes the popped word
        if (IDX == target) begin
          q <= ctl.data;
        end else begin
          q <= right;
        end
      end
      OP_DROP: begin
        q <= right;
      end
      default: begin
        q <= q;
      end
    endcase
  end

endmodule
